FILE: hdl/descriptor_slot_table_macros.svh
// Assertion macros for the descriptor slot table.
`ifndef DESCRIPTOR_SLOT_TABLE_MACROS_SVH
`define DESCRIPTOR_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DST_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("descriptor_slot_table: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("descriptor_slot_table: check failed");

`endif

FILE: hdl/dst_pkg.sv
// Types and constants shared by the descriptor slot table modules.
`default_nettype none

package dst_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int FIRST_FREE = 3;
	localparam int FD_W       = 9;
	localparam int RES_W      = 8;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int GROUP_W    = 16;
	localparam int NUM_GROUPS = TABLE_SIZE / GROUP_W;
	localparam int LOC_W      = $clog2(GROUP_W);
	localparam int GRP_W      = $clog2(NUM_GROUPS);

	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_CLOSE = 3'd1,
		OP_GET   = 3'd2,
		OP_SET   = 3'd3,
		OP_DUP   = 3'd4,
		OP_DUP2  = 3'd5
	} dst_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} dst_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EXEC
	} dst_state_t;

	typedef struct packed {
		logic [2:0]      op;
		logic [FD_W-1:0] fd;
		logic [FD_W-1:0] second_fd;
		logic [31:0]     inode_id;
		logic [63:0]     file_offset;
		logic [15:0]     open_flags;
		logic            close_on_exec;
		logic            entry_present;
	} dst_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [RES_W-1:0] result_fd;
		logic             slot_valid;
		logic [31:0]      out_inode;
		logic [63:0]      out_offset;
		logic [15:0]      out_flags;
		logic             out_cloexec;
	} dst_rsp_t;

	typedef struct packed {
		logic [31:0] inode;
		logic [63:0] offset;
		logic [15:0] flags;
		logic        cloexec;
	} dst_entry_t;

	typedef struct packed {
		logic latch;
		logic lookup;
		logic exec;
	} dst_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/dst_ctrl.sv
// Controller state machine for the descriptor slot table.
`default_nettype none

module dst_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output dst_pkg::dst_cmd_t   cmd,
	output logic                busy,
	output logic                done
);

	dst_pkg::dst_state_t state_q;
	dst_pkg::dst_state_t state_d;
	logic                done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dst_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == dst_pkg::S_EXEC);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dst_pkg::S_IDLE: begin
				if (start) state_d = dst_pkg::S_READ;
			end
			dst_pkg::S_READ: state_d = dst_pkg::S_EXEC;
			dst_pkg::S_EXEC: state_d = dst_pkg::S_IDLE;
			default:         state_d = dst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			dst_pkg::S_IDLE: begin
				busy      = 1'b0;
				cmd.latch = start;
			end
			dst_pkg::S_READ: cmd.lookup = 1'b1;
			dst_pkg::S_EXEC: cmd.exec = 1'b1;
			default:         busy = 1'b0;
		endcase
	end

	assign done = done_q;

endmodule

`default_nettype wire

FILE: hdl/dst_dpath.sv
// Datapath: valid marks, entry store, free-slot search and result register.
`default_nettype none

module dst_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dst_pkg::dst_cmd_t cmd,
	input  wire dst_pkg::dst_req_t req,
	output dst_pkg::dst_rsp_t      rsp
);

	localparam int TS = dst_pkg::TABLE_SIZE;
	localparam int GW = dst_pkg::GROUP_W;
	localparam int NG = dst_pkg::NUM_GROUPS;

	function automatic logic [dst_pkg::LOC_W-1:0] low_loc(input logic [GW-1:0] v);
		logic [dst_pkg::LOC_W-1:0] idx;
		idx = '0;
		for (int i = GW - 1; i >= 0; i--) begin
			if (v[i]) idx = dst_pkg::LOC_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [dst_pkg::GRP_W-1:0] low_grp(input logic [NG-1:0] v);
		logic [dst_pkg::GRP_W-1:0] idx;
		idx = '0;
		for (int i = NG - 1; i >= 0; i--) begin
			if (v[i]) idx = dst_pkg::GRP_W'(i);
		end
		return idx;
	endfunction

	dst_pkg::dst_req_t   req_q;
	dst_pkg::dst_rsp_t   rsp_q;
	dst_pkg::dst_rsp_t   rsp_d;
	logic [TS-1:0]       valid_q;
	dst_pkg::dst_entry_t mem [TS];
	dst_pkg::dst_entry_t rdata_s1;
	logic                src_ok_s1;
	logic [NG-1:0]       grp_any_s1;
	logic [dst_pkg::LOC_W-1:0] grp_idx_s1 [NG];

	logic [dst_pkg::FD_W-1:0]   start_c;
	logic [TS-1:0]              free_c;
	logic [dst_pkg::GRP_W-1:0]  grp_sel;
	logic [dst_pkg::SLOT_W-1:0] free_slot;
	logic                       free_found;
	logic [dst_pkg::SLOT_W-1:0] fd_slot;
	logic [dst_pkg::SLOT_W-1:0] fd2_slot;
	logic                       fd_in;
	logic                       fd2_in;
	logic                       wr_en;
	logic                       v_set;
	logic                       v_clr;
	logic [dst_pkg::SLOT_W-1:0] wr_slot;
	dst_pkg::dst_entry_t        wr_entry;
	logic                       get_hit;
	dst_pkg::dst_status_t       status_c;
	logic [dst_pkg::SLOT_W-1:0] res_slot;

	assign fd_slot  = req_q.fd[dst_pkg::SLOT_W-1:0];
	assign fd2_slot = req_q.second_fd[dst_pkg::SLOT_W-1:0];
	assign fd_in    = req_q.fd < dst_pkg::FD_W'(TS);
	assign fd2_in   = req_q.second_fd < dst_pkg::FD_W'(TS);

	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= req;
	end

	always_comb begin
		start_c = dst_pkg::FD_W'(dst_pkg::FIRST_FREE);
		if (req_q.op == dst_pkg::OP_DUP
				&& req_q.second_fd > dst_pkg::FD_W'(dst_pkg::FIRST_FREE)) begin
			start_c = req_q.second_fd;
		end
		for (int i = 0; i < TS; i++) begin
			free_c[i] = !valid_q[i] && (dst_pkg::FD_W'(i) >= start_c);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			rdata_s1  <= mem[fd_slot];
			src_ok_s1 <= fd_in && valid_q[fd_slot];
			for (int g = 0; g < NG; g++) begin
				grp_any_s1[g] <= |free_c[g*GW +: GW];
				grp_idx_s1[g] <= low_loc(free_c[g*GW +: GW]);
			end
		end
		if (wr_en) mem[wr_slot] <= wr_entry;
	end

	assign grp_sel    = low_grp(grp_any_s1);
	assign free_found = |grp_any_s1;
	assign free_slot  = {grp_sel, grp_idx_s1[grp_sel]};

	always_comb begin
		status_c = dst_pkg::ST_BAD;
		res_slot = '0;
		wr_en    = 1'b0;
		v_set    = 1'b0;
		v_clr    = 1'b0;
		wr_slot  = fd_slot;
		wr_entry = rdata_s1;
		get_hit  = 1'b0;
		case (req_q.op)
			dst_pkg::OP_ALLOC: begin
				wr_entry.inode   = req_q.inode_id;
				wr_entry.offset  = '0;
				wr_entry.flags   = req_q.open_flags;
				wr_entry.cloexec = 1'b0;
				wr_slot          = free_slot;
				if (free_found) begin
					status_c = dst_pkg::ST_OK;
					res_slot = free_slot;
					wr_en    = 1'b1;
					v_set    = 1'b1;
				end else begin
					status_c = dst_pkg::ST_FULL;
				end
			end
			dst_pkg::OP_CLOSE: begin
				if (src_ok_s1) begin
					status_c = dst_pkg::ST_OK;
					res_slot = fd_slot;
					v_clr    = 1'b1;
				end
			end
			dst_pkg::OP_GET: begin
				if (src_ok_s1) begin
					status_c = dst_pkg::ST_OK;
					res_slot = fd_slot;
					get_hit  = 1'b1;
				end
			end
			dst_pkg::OP_SET: begin
				wr_entry.inode   = req_q.inode_id;
				wr_entry.offset  = req_q.file_offset;
				wr_entry.flags   = req_q.open_flags;
				wr_entry.cloexec = req_q.close_on_exec;
				if (fd_in) begin
					status_c = dst_pkg::ST_OK;
					res_slot = fd_slot;
					wr_en    = req_q.entry_present;
					v_set    = req_q.entry_present;
					v_clr    = !req_q.entry_present;
				end
			end
			dst_pkg::OP_DUP: begin
				wr_slot = free_slot;
				if (src_ok_s1) begin
					if (free_found) begin
						status_c = dst_pkg::ST_OK;
						res_slot = free_slot;
						wr_en    = 1'b1;
						v_set    = 1'b1;
					end else begin
						status_c = dst_pkg::ST_FULL;
					end
				end
			end
			dst_pkg::OP_DUP2: begin
				wr_slot = fd2_slot;
				if (src_ok_s1 && fd2_in) begin
					status_c = dst_pkg::ST_OK;
					res_slot = fd2_slot;
					wr_en    = req_q.second_fd != req_q.fd;
					v_set    = req_q.second_fd != req_q.fd;
				end
			end
			default: status_c = dst_pkg::ST_BAD;
		endcase
		wr_en = wr_en && cmd.exec;
		v_set = v_set && cmd.exec;
		v_clr = v_clr && cmd.exec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (v_set) valid_q[wr_slot] <= 1'b1;
			if (v_clr) valid_q[fd_slot] <= 1'b0;
		end
	end

	always_comb begin
		rsp_d             = '0;
		rsp_d.status      = status_c;
		rsp_d.result_fd   = dst_pkg::RES_W'(res_slot);
		rsp_d.slot_valid  = get_hit;
		if (get_hit) begin
			rsp_d.out_inode   = rdata_s1.inode;
			rsp_d.out_offset  = rdata_s1.offset;
			rsp_d.out_flags   = rdata_s1.flags;
			rsp_d.out_cloexec = rdata_s1.cloexec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) rsp_q <= rsp_d;
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

FILE: hdl/descriptor_slot_table.sv
// A beat accepted while idle passes through the lookup and execute states; done is registered from execute.
// A new beat is taken only once the block is back in idle; busy stays high for the lookup and execute cycles.
// The lookup cycle reads the entry store and registers the free-slot group tree.
// Reset clears every valid mark at once; the entry store itself is not cleared.
// Each result is held on rsp until the next execute and is marked by done for exactly one cycle; it cannot be stalled.
`default_nettype none

`include "descriptor_slot_table_macros.svh"

module descriptor_slot_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire dst_pkg::dst_req_t req,
	output logic                   done,
	output dst_pkg::dst_rsp_t      rsp
);

	dst_pkg::dst_cmd_t cmd;

	dst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dst_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	`DST_ASSERT_IMPL(a_accept_to_done, start && !busy, ##3 done)
	`DST_ASSERT_IMPL(a_done_when_idle, done, !busy)
	`DST_ASSERT_IMPL(a_fail_clean, done && rsp.status != dst_pkg::ST_OK, rsp.result_fd == '0 && !rsp.slot_valid)
	`DST_ASSERT_NEXT(a_one_strobe, done, !done)

endmodule

`default_nettype wire

FILE: verif/descriptor_slot_table_tb.sv
// Testbench for the descriptor slot table: directed table, then random beats against a predictor.
`default_nettype none

module descriptor_slot_table_tb;

	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;
	localparam logic [dst_pkg::FD_W-1:0] FD_LIMIT = dst_pkg::FD_W'(dst_pkg::TABLE_SIZE);
	localparam logic [dst_pkg::FD_W-1:0] FD_FIRST = dst_pkg::FD_W'(dst_pkg::FIRST_FREE);
	localparam int N_DIRECTED = 25;
	localparam int GROW_BEATS = 330;
	localparam int SHRINK_BEATS = 150;

	typedef struct packed {
		dst_pkg::dst_req_t beat;
		logic              typed;
		dst_pkg::dst_rsp_t want;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	dst_pkg::dst_req_t req = '0;
	logic              busy;
	logic              done;
	dst_pkg::dst_rsp_t rsp;

	logic                open_mark [dst_pkg::TABLE_SIZE];
	dst_pkg::dst_entry_t fd_entry [dst_pkg::TABLE_SIZE];
	dst_pkg::dst_rsp_t   pending_rsp [$];
	int                  fail_count = 0;
	int                  idle_pct = 0;
	directed_row_t       plan [N_DIRECTED];

	descriptor_slot_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	function automatic dst_pkg::dst_req_t mk_req(logic [2:0] op, logic [dst_pkg::FD_W-1:0] fd,
			logic [dst_pkg::FD_W-1:0] fd2, logic [31:0] ino, logic [63:0] off,
			logic [15:0] fl, logic ce, logic pres);
		dst_pkg::dst_req_t b;
		b.op = op;
		b.fd = fd;
		b.second_fd = fd2;
		b.inode_id = ino;
		b.file_offset = off;
		b.open_flags = fl;
		b.close_on_exec = ce;
		b.entry_present = pres;
		return b;
	endfunction

	function automatic dst_pkg::dst_rsp_t mk_rsp(logic [1:0] st,
			logic [dst_pkg::RES_W-1:0] fd, logic v,
			logic [31:0] ino, logic [63:0] off, logic [15:0] fl, logic ce);
		dst_pkg::dst_rsp_t r;
		r.status = st;
		r.result_fd = fd;
		r.slot_valid = v;
		r.out_inode = ino;
		r.out_offset = off;
		r.out_flags = fl;
		r.out_cloexec = ce;
		return r;
	endfunction

	function automatic int lowest_free_fd(int from);
		for (int i = from; i < dst_pkg::TABLE_SIZE; i++) begin
			if (!open_mark[dst_pkg::SLOT_W'(i)])
				return i;
		end
		return dst_pkg::TABLE_SIZE;
	endfunction

	function automatic dst_pkg::dst_rsp_t run_fd_op(dst_pkg::dst_req_t b);
		dst_pkg::dst_rsp_t          r;
		logic                       src_ok;
		int                         s;
		int                         from;
		logic [dst_pkg::SLOT_W-1:0] fd_s;
		logic [dst_pkg::SLOT_W-1:0] fd2_s;
		logic [dst_pkg::SLOT_W-1:0] s_idx;
		dst_pkg::dst_entry_t        src;
		r = '0;
		r.status = dst_pkg::ST_BAD;
		fd_s = b.fd[dst_pkg::SLOT_W-1:0];
		fd2_s = b.second_fd[dst_pkg::SLOT_W-1:0];
		src_ok = (b.fd < FD_LIMIT) ? open_mark[fd_s] : 1'b0;
		src = src_ok ? fd_entry[fd_s] : '0;
		case (b.op)
			dst_pkg::OP_ALLOC: begin
				s = lowest_free_fd(dst_pkg::FIRST_FREE);
				if (s < dst_pkg::TABLE_SIZE) begin
					s_idx = s[dst_pkg::SLOT_W-1:0];
					open_mark[s_idx] = 1'b1;
					fd_entry[s_idx] = '{inode: b.inode_id, offset: 64'd0,
						flags: b.open_flags, cloexec: 1'b0};
					r.status = dst_pkg::ST_OK;
					r.result_fd = s[dst_pkg::RES_W-1:0];
				end else begin
					r.status = dst_pkg::ST_FULL;
				end
			end
			dst_pkg::OP_CLOSE: begin
				if (src_ok) begin
					open_mark[fd_s] = 1'b0;
					r.status = dst_pkg::ST_OK;
					r.result_fd = b.fd[dst_pkg::RES_W-1:0];
				end
			end
			dst_pkg::OP_GET: begin
				if (src_ok) begin
					r.status = dst_pkg::ST_OK;
					r.result_fd = b.fd[dst_pkg::RES_W-1:0];
					r.slot_valid = 1'b1;
					r.out_inode = src.inode;
					r.out_offset = src.offset;
					r.out_flags = src.flags;
					r.out_cloexec = src.cloexec;
				end
			end
			dst_pkg::OP_SET: begin
				if (b.fd < FD_LIMIT) begin
					open_mark[fd_s] = b.entry_present;
					if (b.entry_present)
						fd_entry[fd_s] = '{inode: b.inode_id, offset: b.file_offset,
							flags: b.open_flags, cloexec: b.close_on_exec};
					r.status = dst_pkg::ST_OK;
					r.result_fd = b.fd[dst_pkg::RES_W-1:0];
				end
			end
			dst_pkg::OP_DUP: begin
				if (src_ok) begin
					from = (b.second_fd < FD_FIRST) ? dst_pkg::FIRST_FREE : int'(b.second_fd);
					s = lowest_free_fd(from);
					if (s < dst_pkg::TABLE_SIZE) begin
						s_idx = s[dst_pkg::SLOT_W-1:0];
						open_mark[s_idx] = 1'b1;
						fd_entry[s_idx] = src;
						r.status = dst_pkg::ST_OK;
						r.result_fd = s[dst_pkg::RES_W-1:0];
					end else begin
						r.status = dst_pkg::ST_FULL;
					end
				end
			end
			dst_pkg::OP_DUP2: begin
				if (src_ok && b.second_fd < FD_LIMIT) begin
					open_mark[fd2_s] = 1'b1;
					fd_entry[fd2_s] = src;
					r.status = dst_pkg::ST_OK;
					r.result_fd = b.second_fd[dst_pkg::RES_W-1:0];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic dst_pkg::dst_req_t random_beat(logic grow);
		dst_pkg::dst_req_t          b;
		int                         pick;
		logic [dst_pkg::SLOT_W-1:0] probe;
		b.fd = ($urandom_range(15) == 0) ? dst_pkg::FD_W'($urandom_range(511, 256))
			: dst_pkg::FD_W'($urandom_range(255));
		b.second_fd = ($urandom_range(15) == 0) ? dst_pkg::FD_W'($urandom_range(511, 256))
			: dst_pkg::FD_W'($urandom_range(255));
		b.inode_id = $urandom;
		b.file_offset = {$urandom, $urandom};
		b.open_flags = 16'($urandom);
		b.close_on_exec = 1'($urandom_range(1));
		b.entry_present = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 2)
			b.op = ($urandom_range(1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
		else if (grow)
			b.op = (pick < 50) ? dst_pkg::OP_ALLOC : (pick < 68) ? dst_pkg::OP_DUP :
				(pick < 73) ? dst_pkg::OP_DUP2 : (pick < 80) ? dst_pkg::OP_SET :
				(pick < 92) ? dst_pkg::OP_GET : dst_pkg::OP_CLOSE;
		else
			b.op = (pick < 10) ? dst_pkg::OP_ALLOC : (pick < 15) ? dst_pkg::OP_DUP :
				(pick < 20) ? dst_pkg::OP_DUP2 : (pick < 40) ? dst_pkg::OP_SET :
				(pick < 55) ? dst_pkg::OP_GET : dst_pkg::OP_CLOSE;
		// aim most sources at open slots
		if (b.op != dst_pkg::OP_ALLOC && b.op != dst_pkg::OP_SET && b.fd < FD_LIMIT
				&& $urandom_range(3) != 0) begin
			for (int i = 0; i < 8; i++) begin
				probe = dst_pkg::SLOT_W'($urandom_range(255));
				if (open_mark[probe]) begin
					b.fd = dst_pkg::FD_W'(probe);
					break;
				end
			end
		end
		if (b.op == dst_pkg::OP_DUP && $urandom_range(3) == 0)
			b.second_fd = dst_pkg::FD_W'($urandom_range(3));
		if (b.op == dst_pkg::OP_DUP2 && $urandom_range(9) == 0)
			b.second_fd = b.fd;
		return b;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic issue_beat(dst_pkg::dst_req_t b, logic typed, dst_pkg::dst_rsp_t want);
		dst_pkg::dst_rsp_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = run_fd_op(b);
		pending_rsp.push_back(typed ? want : predicted);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsp.size() != 0);
	endtask

	always @(posedge clk) begin
		dst_pkg::dst_rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result beat with no request outstanding");
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("result_fd", want.result_fd, rsp.result_fd);
				check_field("slot_valid", want.slot_valid, rsp.slot_valid);
				check_field("out_inode", want.out_inode, rsp.out_inode);
				check_field("out_offset", want.out_offset, rsp.out_offset);
				check_field("out_flags", want.out_flags, rsp.out_flags);
				check_field("out_cloexec", want.out_cloexec, rsp.out_cloexec);
			end
		end
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		for (int i = 0; i < dst_pkg::TABLE_SIZE; i++) begin
			open_mark[i] = 1'b0;
			fd_entry[i] = '0;
		end
		plan[0]  = '{mk_req(dst_pkg::OP_GET, 9'd0, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[1]  = '{mk_req(dst_pkg::OP_CLOSE, 9'd511, 9'd511, 32'd0, 64'd0, 16'd0, 1'b0,
			1'b0), 1'b1, mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[2]  = '{mk_req(dst_pkg::OP_ALLOC, 9'd0, 9'd0, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b1), 1'b1,
			mk_rsp(dst_pkg::ST_OK, 8'd3, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[3]  = '{mk_req(dst_pkg::OP_ALLOC, 9'd0, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_OK, 8'd4, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[4]  = '{mk_req(dst_pkg::OP_GET, 9'd3, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_rsp(dst_pkg::ST_OK, 8'd3, 1'b1, 32'hFFFF_FFFF, 64'd0, 16'hFFFF, 1'b0)};
		plan[5]  = '{mk_req(dst_pkg::OP_SET, 9'd255, 9'd0, 32'hA5A5_A5A5,
			64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, 1'b1, 1'b1), 1'b1,
			mk_rsp(dst_pkg::ST_OK, 8'hFF, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[6]  = '{mk_req(dst_pkg::OP_GET, 9'd255, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_OK, 8'hFF, 1'b1, 32'hA5A5_A5A5,
			64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, 1'b1)};
		plan[7]  = '{mk_req(dst_pkg::OP_SET, 9'd256, 9'd0, 32'd1, 64'd1, 16'd1, 1'b1, 1'b1),
			1'b1, mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[8]  = '{mk_req(dst_pkg::OP_SET, 9'd0, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_rsp(dst_pkg::ST_OK, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[9]  = '{mk_req(dst_pkg::OP_SET, 9'd0, 9'd0, 32'h1234_5678, 64'h0, 16'h0001, 1'b0,
			1'b1), 1'b1, mk_rsp(dst_pkg::ST_OK, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[10] = '{mk_req(dst_pkg::OP_DUP, 9'd255, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_OK, 8'd5, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[11] = '{mk_req(dst_pkg::OP_DUP, 9'd255, 9'd255, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_FULL, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[12] = '{mk_req(dst_pkg::OP_DUP, 9'd255, 9'd511, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_FULL, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[13] = '{mk_req(dst_pkg::OP_DUP, 9'd7, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[14] = '{mk_req(dst_pkg::OP_DUP2, 9'd3, 9'd3, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_OK, 8'd3, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[15] = '{mk_req(dst_pkg::OP_DUP2, 9'd3, 9'd256, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[16] = '{mk_req(dst_pkg::OP_DUP2, 9'd255, 9'd3, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_OK, 8'd3, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[17] = '{mk_req(dst_pkg::OP_GET, 9'd3, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0), 1'b0,
			'0};
		plan[18] = '{mk_req(dst_pkg::OP_CLOSE, 9'd3, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_OK, 8'd3, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[19] = '{mk_req(dst_pkg::OP_CLOSE, 9'd3, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[20] = '{mk_req(OP_UNUSED_6, 9'd4, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b1), 1'b1,
			mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[21] = '{mk_req(OP_UNUSED_7, 9'd4, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b1), 1'b1,
			mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};
		plan[22] = '{mk_req(dst_pkg::OP_DUP2, 9'd4, 9'd200, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b0, '0};
		plan[23] = '{mk_req(dst_pkg::OP_DUP, 9'd0, 9'd2, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0), 1'b0,
			'0};
		plan[24] = '{mk_req(dst_pkg::OP_GET, 9'd511, 9'd0, 32'd0, 64'd0, 16'd0, 1'b0, 1'b0),
			1'b1, mk_rsp(dst_pkg::ST_BAD, 8'd0, 1'b0, 32'd0, 64'd0, 16'd0, 1'b0)};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 24;
		for (int i = 0; i < N_DIRECTED; i++)
			issue_beat(plan[i].beat, plan[i].typed, plan[i].want);
		wait_all_results();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 24 : (phase == 1) ? 50 : 0;
			for (int k = 0; k < GROW_BEATS + SHRINK_BEATS; k++) begin
				issue_beat(random_beat(k < GROW_BEATS), 1'b0, '0);
				if ($urandom_range(199) == 0)
					wait_all_results();
			end
			wait_all_results();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
